### rtl/rlf_pkg.sv
// Package for the RGB LED fade engine: constants, codes, payload types and helpers.
`default_nettype none
package rlf_pkg;

   localparam int MAX_LEDS   = 32;
   localparam int PWM_GROUPS = 4;
   localparam int LED_W      = 5;
   localparam int CNT_W      = 6;
   localparam int MS_W       = 20;
   localparam int IV_W       = 10;

   localparam logic [31:0] TARGET_LSB = 32'h0040_0000;
   localparam logic [31:0] ADJUST_CAP = 32'h2AAA_A000;

   localparam logic [1:0] REQ_COLOUR = 2'd0;
   localparam logic [1:0] REQ_DIM    = 2'd1;
   localparam logic [1:0] REQ_KIND   = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_PWM    = 2'd1;
   localparam logic [1:0] KIND_SERIAL = 2'd2;
   localparam logic [1:0] KIND_OTHER  = 2'd3;

   localparam logic [1:0] ITEM_STATUS = 2'd0;
   localparam logic [1:0] ITEM_PWM    = 2'd1;
   localparam logic [1:0] ITEM_SERIAL = 2'd2;
   localparam logic [1:0] ITEM_DARK   = 2'd3;

   localparam logic [1:0] WMODE_NONE   = 2'd0;
   localparam logic [1:0] WMODE_ADD    = 2'd1;
   localparam logic [1:0] WMODE_ADJUST = 2'd2;
   localparam logic [1:0] WMODE_EXTRA  = 2'd3;

   localparam logic [1:0] WACT_NONE  = 2'd0;
   localparam logic [1:0] WACT_WHITE = 2'd1;
   localparam logic [1:0] WACT_EXTRA = 2'd2;

   localparam logic [1:0] CSR_LED_COUNT = 2'd0;
   localparam logic [1:0] CSR_WHITE     = 2'd1;
   localparam logic [1:0] CSR_INTERVAL  = 2'd2;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [LED_W-1:0] idx;
      logic [LED_W-1:0] last;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [MS_W-1:0]  ms;
      logic [3:0]       dim;
      logic [1:0]       kind;
      logic             ok;
   } cmd_type;

   typedef struct packed {
      logic [31:0]     lev_r;
      logic [31:0]     lev_g;
      logic [31:0]     lev_b;
      logic [31:0]     stp_r;
      logic [31:0]     stp_g;
      logic [31:0]     stp_b;
      logic [MS_W-1:0] ticks;
      logic [3:0]      dim;
      logic [1:0]      kind;
   } led_type;

   // White mode of a pwm group; groups that do not exist read as none.
   function automatic logic [1:0] white_mode(input logic [7:0] modes, input logic [5:0] g);
      logic [7:0] sh;
      sh = modes >> {g[1:0], 1'b0};
      if (g < 6'(PWM_GROUPS) && g < 6'd4) begin
         return sh[1:0];
      end
      return WMODE_NONE;
   endfunction

   function automatic logic [31:0] min3(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
      logic [31:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage
`default_nettype wire

### rtl/rlf_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 20-bit divisor.
`default_nettype none
module rlf_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [19:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   import rlf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] dvs_ff, dvs_in;
   logic [20:0] trial;
   logic [20:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[20]) begin
            rem_in = diff[19:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[19:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### rtl/rlf_front.sv
// Front end: takes request transactions, checks indices and hands commands on.
`default_nettype none
module rlf_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_type,
   input  wire logic [rlf_pkg::LED_W-1:0] req_led_index,
   input  wire logic [rlf_pkg::LED_W-1:0] req_led_last,
   input  wire logic [7:0]               req_red_in,
   input  wire logic [7:0]               req_green_in,
   input  wire logic [7:0]               req_blue_in,
   input  wire logic [rlf_pkg::MS_W-1:0] req_duration_ms,
   input  wire logic [3:0]               req_dim_shift,
   input  wire logic [1:0]               req_led_kind,
   input  wire logic [rlf_pkg::CNT_W-1:0] led_count,
   input  wire logic                     q_full,
   output logic                          q_push,
   output rlf_pkg::cmd_type              q_data
);
   import rlf_pkg::*;

   cmd_type cmd_ff, cmd_in;
   logic    vld_ff, vld_in;
   logic    take;
   logic    ok;

   always_comb begin
      case (req_type)
         REQ_COLOUR, REQ_DIM: ok = {1'b0, req_led_index} < led_count;
         REQ_KIND: ok = ({1'b0, req_led_last} < led_count) && (req_led_index < req_led_last);
         default: ok = 1'b0;
      endcase
   end

   assign q_push    = vld_ff && !q_full;
   assign req_stall = vld_ff && q_full;
   assign take      = req_valid && !req_stall;

   always_comb begin
      cmd_in = cmd_ff;
      vld_in = vld_ff && !q_push;
      if (take) begin
         vld_in          = 1'b1;
         cmd_in.req_type = req_type;
         cmd_in.idx      = req_led_index;
         cmd_in.last     = req_led_last;
         cmd_in.red      = req_red_in;
         cmd_in.green    = req_green_in;
         cmd_in.blue     = req_blue_in;
         cmd_in.ms       = req_duration_ms;
         cmd_in.dim      = req_dim_shift;
         cmd_in.kind     = req_led_kind;
         cmd_in.ok       = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

   assign q_data = cmd_ff;

endmodule
`default_nettype wire

### rtl/rlf_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module rlf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rlf_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output rlf_pkg::cmd_type      head
);
   import rlf_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = mem_ff[rp_ff];

endmodule
`default_nettype wire

### rtl/rlf_back.sv
// Back end: per-LED state, fade planning, tick walk, gamma and white, result register.
`default_nettype none
module rlf_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  wire logic [rlf_pkg::CNT_W-1:0] led_count,
   input  wire logic [7:0]                white_modes,
   input  wire logic [rlf_pkg::IV_W-1:0]  tick_interval_ms,
   input  wire logic                      q_not_empty,
   input  wire rlf_pkg::cmd_type          q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_item_kind,
   output logic [rlf_pkg::LED_W-1:0]      rsp_led_number,
   output logic [rlf_pkg::LED_W-1:0]      rsp_pwm_channel,
   output logic [31:0]                    rsp_red_out,
   output logic [31:0]                    rsp_green_out,
   output logic [31:0]                    rsp_blue_out,
   output logic [1:0]                     rsp_white_action,
   output logic [1:0]                     rsp_white_group,
   output logic [31:0]                    rsp_white_out,
   output logic                           rsp_chain_start,
   output logic                           rsp_last_item,
   output logic                           rsp_accepted
);
   import rlf_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_NWAIT = 9'b000000010,
      ST_SWAIT = 9'b000000100,
      ST_KIND  = 9'b000001000,
      ST_T0    = 9'b000010000,
      ST_T1    = 9'b000100000,
      ST_T2    = 9'b001000000,
      ST_T3    = 9'b010000000,
      ST_STAT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   led_type         led_ff [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff, valid_in;
   logic [MAX_LEDS-1:0] mov_ff, mov_in;

   cmd_type         cur_ff, cur_in;
   logic [LED_W-1:0] i_ff, i_in;
   logic [5:0]      pch_ff, pch_in;
   logic            ser_ff, ser_in;
   logic [1:0]      chan_ff, chan_in;
   logic [MS_W-1:0] n_ff, n_in;
   logic [31:0]     sr_ff, sr_in, sg_ff, sg_in;

   logic [31:0] lr_ff, lr_in, lg_ff, lg_in, lb_ff, lb_in, lw_ff, lw_in;
   logic [3:0]  d_ff, d_in;
   logic [1:0]  k_ff, k_in;

   // Result register
   logic        ov_ff, ov_in;
   logic [1:0]  okind_ff, okind_in;
   logic [LED_W-1:0] onum_ff, onum_in, opch_ff, opch_in;
   logic [31:0] or_ff, or_in, og_ff, og_in, ob_ff, ob_in, ow_ff, ow_in;
   logic [1:0]  oact_ff, oact_in, ogrp_ff, ogrp_in;
   logic        ocs_ff, ocs_in, olast_ff, olast_in, oacc_ff, oacc_in;

   logic            out_free;
   logic [LED_W-1:0] rd_addr;
   led_type         rd;
   logic            we;
   led_type         wd;

   logic            div_start, div_done;
   logic [31:0]     div_a, div_q;
   logic [19:0]     div_b;
   logic [IV_W-1:0] iv;
   logic [31:0]     tgt [3];
   logic [31:0]     lev [3];
   logic [31:0]     dif [3];
   logic [31:0]     mag [3];
   logic [1:0]      csel;
   logic [31:0]     step_new;
   logic [1:0]      m;
   logic [31:0]     w, cr, cg, cb;
   logic [31:0]     sq_r, sq_g, sq_b, sq_w;
   logic [1:0]      act, grp;
   logic [31:0]     wout;
   logic            last_led;

   rlf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_free = !ov_ff || !rsp_stall;
   assign iv       = (tick_interval_ms == '0) ? IV_W'(1) : tick_interval_ms;
   assign rd_addr  = (state_ff == ST_KIND || state_ff == ST_T0) ? i_ff : cur_ff.idx;
   assign rd       = valid_ff[rd_addr] ? led_ff[rd_addr] : '0;
   assign last_led = (6'(i_ff) + 6'd1) == led_count;

   always_comb begin
      tgt[0] = {cur_ff.red, 24'h0} | TARGET_LSB;
      tgt[1] = {cur_ff.green, 24'h0} | TARGET_LSB;
      tgt[2] = {cur_ff.blue, 24'h0} | TARGET_LSB;
      tgt[0][23] = 1'b0;
      tgt[1][23] = 1'b0;
      tgt[2][23] = 1'b0;
      tgt[0] = {cur_ff.red, 23'h0} | TARGET_LSB;
      tgt[1] = {cur_ff.green, 23'h0} | TARGET_LSB;
      tgt[2] = {cur_ff.blue, 23'h0} | TARGET_LSB;
      lev[0] = rd.lev_r;
      lev[1] = rd.lev_g;
      lev[2] = rd.lev_b;
      for (int c = 0; c < 3; c++) begin
         dif[c] = tgt[c] - lev[c];
         mag[c] = dif[c][31] ? (32'd0 - dif[c]) : dif[c];
      end
      csel     = (state_ff == ST_NWAIT) ? 2'd0 : chan_ff + 2'd1;
      step_new = dif[chan_ff][31] ? (32'd0 - div_q) : div_q;
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_a     = mag[csel];
      div_b     = n_ff;
      case (state_ff)
         ST_IDLE: begin
            div_a     = 32'(q_head.ms);
            div_b     = 20'(iv);
            div_start = q_not_empty && q_head.req_type == REQ_COLOUR && q_head.ok;
         end
         ST_NWAIT: begin
            div_b     = div_q[19:0];
            div_start = div_done && div_q[31:1] != '0;
         end
         ST_SWAIT: begin
            div_start = div_done && chan_ff != 2'd2;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // White derivation on the stepped levels
   always_comb begin
      m  = (k_ff == KIND_PWM) ? white_mode(white_modes, pch_ff) : WMODE_NONE;
      w  = '0;
      cr = lr_ff;
      cg = lg_ff;
      cb = lb_ff;
      if (m == WMODE_ADD || m == WMODE_ADJUST) begin
         w = min3(lr_ff, lg_ff, lb_ff);
         if (m == WMODE_ADJUST) begin
            if (w > ADJUST_CAP) begin
               w = ADJUST_CAP;
            end
            cr = lr_ff - w;
            cg = lg_ff - w;
            cb = lb_ff - w;
            w  = w + {w[30:0], 1'b0};
         end
      end
   end

   assign sq_r = lr_ff[30:15] * lr_ff[30:15];
   assign sq_g = lg_ff[30:15] * lg_ff[30:15];
   assign sq_b = lb_ff[30:15] * lb_ff[30:15];
   assign sq_w = lw_ff[30:15] * lw_ff[30:15];

   // White action for the item being emitted (values in l*_ff are squares here)
   always_comb begin
      act  = WACT_NONE;
      grp  = 2'd0;
      wout = '0;
      if (k_ff == KIND_PWM) begin
         if (pch_ff < 6'(PWM_GROUPS) &&
             (white_mode(white_modes, pch_ff) == WMODE_ADD ||
              white_mode(white_modes, pch_ff) == WMODE_ADJUST)) begin
            act  = WACT_WHITE;
            grp  = pch_ff[1:0];
            wout = lw_ff >> d_ff;
         end else if (pch_ff >= 6'(PWM_GROUPS) && pch_ff < 6'(2 * PWM_GROUPS) &&
                      white_mode(white_modes, pch_ff - 6'(PWM_GROUPS)) == WMODE_EXTRA) begin
            act  = WACT_EXTRA;
            grp  = 2'(pch_ff - 6'(PWM_GROUPS));
            wout = lr_ff >> d_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      i_in     = i_ff;
      pch_in   = pch_ff;
      ser_in   = ser_ff;
      chan_in  = chan_ff;
      n_in     = n_ff;
      sr_in    = sr_ff;
      sg_in    = sg_ff;
      lr_in    = lr_ff;
      lg_in    = lg_ff;
      lb_in    = lb_ff;
      lw_in    = lw_ff;
      d_in     = d_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      mov_in   = mov_ff;
      q_pop    = 1'b0;
      we       = 1'b0;
      wd       = rd;

      ov_in    = ov_ff && rsp_stall;
      okind_in = okind_ff;
      onum_in  = onum_ff;
      opch_in  = opch_ff;
      or_in    = or_ff;
      og_in    = og_ff;
      ob_in    = ob_ff;
      ow_in    = ow_ff;
      oact_in  = oact_ff;
      ogrp_in  = ogrp_ff;
      ocs_in   = ocs_ff;
      olast_in = olast_ff;
      oacc_in  = oacc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               i_in   = q_head.idx;
               case (q_head.req_type)
                  REQ_COLOUR: state_in = q_head.ok ? ST_NWAIT : ST_STAT;
                  REQ_KIND:   state_in = q_head.ok ? ST_KIND : ST_STAT;
                  REQ_TICK: begin
                     i_in   = '0;
                     pch_in = '0;
                     ser_in = 1'b0;
                     state_in = (mov_ff != '0) ? ST_T0 : ST_IDLE;
                  end
                  default: state_in = ST_STAT;
               endcase
            end
         end
         ST_NWAIT: begin
            if (div_done) begin
               n_in    = div_q[19:0];
               chan_in = 2'd0;
               if (div_q[31:1] == '0) begin
                  we       = 1'b1;
                  wd.lev_r = tgt[0];
                  wd.lev_g = tgt[1];
                  wd.lev_b = tgt[2];
                  wd.stp_r = '0;
                  wd.stp_g = '0;
                  wd.stp_b = '0;
                  wd.ticks = MS_W'(1);
                  valid_in[cur_ff.idx] = 1'b1;
                  mov_in[cur_ff.idx]   = 1'b1;
                  state_in = ST_STAT;
               end else begin
                  state_in = ST_SWAIT;
               end
            end
         end
         ST_SWAIT: begin
            if (div_done) begin
               if (chan_ff == 2'd0) begin
                  sr_in = step_new;
               end
               if (chan_ff == 2'd1) begin
                  sg_in = step_new;
               end
               chan_in = chan_ff + 2'd1;
               if (chan_ff == 2'd2) begin
                  we       = 1'b1;
                  wd.stp_r = sr_ff;
                  wd.stp_g = sg_ff;
                  wd.stp_b = step_new;
                  wd.ticks = n_ff;
                  valid_in[cur_ff.idx] = 1'b1;
                  mov_in[cur_ff.idx]   = 1'b1;
                  state_in = ST_STAT;
               end
            end
         end
         ST_KIND: begin
            we      = 1'b1;
            wd.kind = cur_ff.kind;
            valid_in[i_ff] = 1'b1;
            i_in    = i_ff + LED_W'(1);
            if (i_ff == cur_ff.last) begin
               state_in = ST_STAT;
            end
         end
         ST_T0: begin
            if (rd.ticks != '0) begin
               we       = 1'b1;
               wd.lev_r = rd.lev_r + rd.stp_r;
               wd.lev_g = rd.lev_g + rd.stp_g;
               wd.lev_b = rd.lev_b + rd.stp_b;
               wd.ticks = rd.ticks - MS_W'(1);
               valid_in[i_ff] = 1'b1;
               mov_in[i_ff]   = wd.ticks != '0;
            end
            lr_in    = wd.lev_r;
            lg_in    = wd.lev_g;
            lb_in    = wd.lev_b;
            d_in     = rd.dim;
            k_in     = rd.kind;
            state_in = ST_T1;
         end
         ST_T1: begin
            lr_in    = cr;
            lg_in    = cg;
            lb_in    = cb;
            lw_in    = w;
            state_in = ST_T2;
         end
         ST_T2: begin
            lr_in    = sq_r;
            lg_in    = sq_g;
            lb_in    = sq_b;
            lw_in    = sq_w;
            state_in = ST_T3;
         end
         ST_T3: begin
            if (out_free) begin
               ov_in    = 1'b1;
               onum_in  = i_ff;
               opch_in  = '0;
               or_in    = lr_ff >> d_ff;
               og_in    = lg_ff >> d_ff;
               ob_in    = lb_ff >> d_ff;
               oact_in  = act;
               ogrp_in  = grp;
               ow_in    = wout;
               ocs_in   = 1'b0;
               olast_in = last_led;
               oacc_in  = 1'b0;
               case (k_ff)
                  KIND_PWM: begin
                     okind_in = ITEM_PWM;
                     opch_in  = pch_ff[LED_W-1:0];
                     pch_in   = pch_ff + 6'd1;
                  end
                  KIND_SERIAL: begin
                     okind_in = ITEM_SERIAL;
                     ocs_in   = !ser_ff;
                     ser_in   = 1'b1;
                  end
                  default: okind_in = ITEM_DARK;
               endcase
               i_in     = i_ff + LED_W'(1);
               state_in = last_led ? ST_IDLE : ST_T0;
            end
         end
         ST_STAT: begin
            if (cur_ff.req_type == REQ_DIM && cur_ff.ok) begin
               we     = 1'b1;
               wd.dim = cur_ff.dim;
               valid_in[cur_ff.idx] = 1'b1;
            end
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = ITEM_STATUS;
               onum_in  = cur_ff.idx;
               opch_in  = '0;
               or_in    = '0;
               og_in    = '0;
               ob_in    = '0;
               oact_in  = WACT_NONE;
               ogrp_in  = '0;
               ow_in    = '0;
               ocs_in   = 1'b0;
               olast_in = 1'b1;
               oacc_in  = cur_ff.ok;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear) begin
         valid_in = '0;
         mov_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         mov_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         mov_ff   <= mov_in;
         ov_ff    <= ov_in;
      end
      if (we) begin
         led_ff[rd_addr] <= wd;
      end
      cur_ff   <= cur_in;
      i_ff     <= i_in;
      pch_ff   <= pch_in;
      ser_ff   <= ser_in;
      chan_ff  <= chan_in;
      n_ff     <= n_in;
      sr_ff    <= sr_in;
      sg_ff    <= sg_in;
      lr_ff    <= lr_in;
      lg_ff    <= lg_in;
      lb_ff    <= lb_in;
      lw_ff    <= lw_in;
      d_ff     <= d_in;
      k_ff     <= k_in;
      okind_ff <= okind_in;
      onum_ff  <= onum_in;
      opch_ff  <= opch_in;
      or_ff    <= or_in;
      og_ff    <= og_in;
      ob_ff    <= ob_in;
      ow_ff    <= ow_in;
      oact_ff  <= oact_in;
      ogrp_ff  <= ogrp_in;
      ocs_ff   <= ocs_in;
      olast_ff <= olast_in;
      oacc_ff  <= oacc_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_item_kind    = okind_ff;
   assign rsp_led_number   = onum_ff;
   assign rsp_pwm_channel  = opch_ff;
   assign rsp_red_out      = or_ff;
   assign rsp_green_out    = og_ff;
   assign rsp_blue_out     = ob_ff;
   assign rsp_white_action = oact_ff;
   assign rsp_white_group  = ogrp_ff;
   assign rsp_white_out    = ow_ff;
   assign rsp_chain_start  = ocs_ff;
   assign rsp_last_item    = olast_ff;
   assign rsp_accepted     = oacc_ff;

endmodule
`default_nettype wire

### rtl/rgb_led_fade_gamma_engine.sv
// Top level of the RGB LED fade engine with gamma, dimming and white derivation.
//
//   Channel   Direction  Handshake              Transaction
//   req_*     in         req_valid / req_stall  one command or one tick
//   rsp_*     out        rsp_valid / rsp_stall  one status item or one LED report
//   csr_*     in         csr_we                 one register write
//
// A set-colour command runs up to four divisions in the shared restoring divider
// (duration by tick interval, then one per colour channel). A tick walks each LED
// in use through the step, white, square and output states. Dim writes the LED's
// dim shift, and a kind range writes the LEDs of the range one per cycle.
// Reset is synchronous and clears all LED state; so does every write of led_count.
// A stalled result holds in the output register while the next transaction is
// already taken into the front end and the two-entry queue.
`default_nettype none
module rgb_led_fade_gamma_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [4:0]  req_led_index,
   input  wire logic [4:0]  req_led_last,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [19:0] req_duration_ms,
   input  wire logic [3:0]  req_dim_shift,
   input  wire logic [1:0]  req_led_kind,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_item_kind,
   output logic [4:0]       rsp_led_number,
   output logic [4:0]       rsp_pwm_channel,
   output logic [31:0]      rsp_red_out,
   output logic [31:0]      rsp_green_out,
   output logic [31:0]      rsp_blue_out,
   output logic [1:0]       rsp_white_action,
   output logic [1:0]       rsp_white_group,
   output logic [31:0]      rsp_white_out,
   output logic             rsp_chain_start,
   output logic             rsp_last_item,
   output logic             rsp_accepted
);
   import rlf_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       wm_ff, wm_in;
   logic [IV_W-1:0]  iv_ff, iv_in;
   logic             clear;
   logic             q_full, q_push, q_pop, q_not_empty;
   cmd_type          q_data, q_head;

   // Register writes; led_count saturates at the number of LEDs held.
   always_comb begin
      cnt_in = cnt_ff;
      wm_in  = wm_ff;
      iv_in  = iv_ff;
      clear  = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_LED_COUNT: begin
               cnt_in = (csr_wdata[5:0] > 6'(MAX_LEDS)) ? 6'(MAX_LEDS) : csr_wdata[5:0];
               clear  = 1'b1;
            end
            CSR_WHITE:    wm_in = csr_wdata[7:0];
            CSR_INTERVAL: iv_in = csr_wdata;
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wm_ff  <= '0;
         iv_ff  <= IV_W'(20);
      end else begin
         cnt_ff <= cnt_in;
         wm_ff  <= wm_in;
         iv_ff  <= iv_in;
      end
   end

   rlf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_led_index   (req_led_index),
      .req_led_last    (req_led_last),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_duration_ms (req_duration_ms),
      .req_dim_shift   (req_dim_shift),
      .req_led_kind    (req_led_kind),
      .led_count       (cnt_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_data)
   );

   rlf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rlf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .clear            (clear),
      .led_count        (cnt_ff),
      .white_modes      (wm_ff),
      .tick_interval_ms (iv_ff),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_led_number   (rsp_led_number),
      .rsp_pwm_channel  (rsp_pwm_channel),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_white_action (rsp_white_action),
      .rsp_white_group  (rsp_white_group),
      .rsp_white_out    (rsp_white_out),
      .rsp_chain_start  (rsp_chain_start),
      .rsp_last_item    (rsp_last_item),
      .rsp_accepted     (rsp_accepted)
   );

endmodule
`default_nettype wire

### rtl/rlf_checker.sv
// Port-level assertions for the fade engine, bound to the top level.
`default_nettype none
module rlf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_item_kind,
   input wire logic [31:0] rsp_red_out,
   input wire logic [1:0]  rsp_white_action,
   input wire logic [31:0] rsp_white_out,
   input wire logic        rsp_chain_start,
   input wire logic        rsp_last_item,
   input wire logic        rsp_accepted
);
   import rlf_pkg::*;

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == ITEM_STATUS |-> rsp_last_item)
      else $error("status transaction not marked last");

   a_tick_not_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind != ITEM_STATUS |-> !rsp_accepted)
      else $error("LED report carries accepted");

   a_no_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_white_action == WACT_NONE |-> rsp_white_out == '0)
      else $error("white drive without white action");

   a_chain_serial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chain_start |-> rsp_item_kind == ITEM_SERIAL)
      else $error("chain start on a non-serial item");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out))
      else $error("stalled result changed");

endmodule

bind rgb_led_fade_gamma_engine rlf_checker u_rlf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_item_kind    (rsp_item_kind),
   .rsp_red_out      (rsp_red_out),
   .rsp_white_action (rsp_white_action),
   .rsp_white_out    (rsp_white_out),
   .rsp_chain_start  (rsp_chain_start),
   .rsp_last_item    (rsp_last_item),
   .rsp_accepted     (rsp_accepted)
);
`default_nettype wire
